[design/lbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label bounding-box table package
// Shared transfer types, operation codes and field widths.
// ----------------------------------------------------------------------------
package lbb_pkg;

	localparam int COORD_W = 10;
	localparam int LABEL_W = 8;
	localparam int OP_W    = 2;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Label that never enters the table, besides the background label zero.
	localparam logic [LABEL_W-1:0] LABEL_IGNORED = 8'd255;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [LABEL_W-1:0] pixel_label;
		coord_t             pixel_row;
		coord_t             pixel_col;
	} req_t;

	typedef struct packed {
		logic   present;
		coord_t min_row;
		coord_t max_row;
		coord_t min_col;
		coord_t max_col;
		coord_t center_row;
		coord_t center_col;
	} rsp_t;

	typedef struct packed {
		coord_t min_row;
		coord_t max_row;
		coord_t min_col;
		coord_t max_col;
	} box_t;

	// Write-side control from the update stage into the box store.
	typedef struct packed {
		logic wr_en;
		logic clear_all;
	} store_ctl_t;

endpackage

[design/label_bounding_box_table.sv]
`timescale 1ns / 1ps
// A read is registered into stage 1 at its acceptance, together with the box memory read;
// its result is then registered in the result stage and shows with done high.
// Throughput: one command of any kind per cycle once busy drops after reset; the single
// update stage and the one-entry write bypass around the box memory carry a label hit
// by consecutive pixels. Reset clears every seen bit at once and holds busy high until the
// first edge after release; the receiver cannot stall, so done is a one-cycle strobe.
// ----------------------------------------------------------------------------
// Label bounding-box table
// Keeps the bounding box of every label of a labelled map and answers reads
// with the box, a present flag and the box center.
// ----------------------------------------------------------------------------
module label_bounding_box_table
	import lbb_pkg::*;
#(
	parameter int MAX_DIM    = 1024,
	parameter int NUM_LABELS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output rsp_t rsp,
	output logic done
);

	localparam int LW = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;

	// Wide enough to hold MAX_DIM itself, which may be 65536.
	localparam logic [16:0] MAX_DIM_W    = 17'(MAX_DIM);
	localparam logic [8:0]  NUM_LABELS_W = 9'(NUM_LABELS);

	// Busy is high only from reset until the first clock after release; afterwards every
	// cycle accepts a transfer when start is high.
	logic busy_q;
	logic accept;

	// Stage 1 holds the accepted command while the box memory read lands.
	logic valid_s1;
	req_t req_s1;

	logic          usable;
	logic          in_map;
	logic          pixel_do;
	logic          read_do;
	logic [LW-1:0] label_idx;
	box_t          cur_box;
	logic          cur_seen;
	box_t          new_box;
	store_ctl_t    store_ctl;
	logic          present;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	assign label_idx = req_s1.pixel_label[LW-1:0];

	// Labels zero and 255 mark background and ignored pixels; labels beyond the
	// table are dropped as well, as are pixels that lie outside the map.
	assign usable = (req_s1.pixel_label != '0) &&
		(req_s1.pixel_label != LABEL_IGNORED) &&
		({1'b0, req_s1.pixel_label} < NUM_LABELS_W);
	assign in_map = ({7'd0, req_s1.pixel_row} < MAX_DIM_W) &&
		({7'd0, req_s1.pixel_col} < MAX_DIM_W);

	assign pixel_do = valid_s1 && (req_s1.operation == OP_PIXEL) && usable && in_map;
	assign read_do  = valid_s1 && (req_s1.operation == OP_READ);

	// The memory is addressed straight from the request port so that its read
	// data is ready in the cycle the command sits in stage 1.
	lbb_box_store #(
		.NUM_LABELS(NUM_LABELS),
		.LW        (LW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_label (req.pixel_label[LW-1:0]),
		.cur_label(label_idx),
		.ctl      (store_ctl),
		.wr_label (label_idx),
		.wr_box   (new_box),
		.cur_box  (cur_box),
		.cur_seen (cur_seen)
	);

	// The first pixel of a label opens the box on itself; later pixels widen it.
	always_comb begin
		if (!cur_seen) begin
			new_box.min_row = req_s1.pixel_row;
			new_box.max_row = req_s1.pixel_row;
			new_box.min_col = req_s1.pixel_col;
			new_box.max_col = req_s1.pixel_col;
		end else begin
			new_box.min_row = (req_s1.pixel_row < cur_box.min_row) ?
				req_s1.pixel_row : cur_box.min_row;
			new_box.max_row = (req_s1.pixel_row > cur_box.max_row) ?
				req_s1.pixel_row : cur_box.max_row;
			new_box.min_col = (req_s1.pixel_col < cur_box.min_col) ?
				req_s1.pixel_col : cur_box.min_col;
			new_box.max_col = (req_s1.pixel_col > cur_box.max_col) ?
				req_s1.pixel_col : cur_box.max_col;
		end
	end

	assign store_ctl.wr_en     = pixel_do;
	assign store_ctl.clear_all = valid_s1 && (req_s1.operation == OP_CLEAR);

	// A box whose maximum row or column is zero reads as absent.
	assign present = usable && cur_seen && (cur_box.max_row != '0) &&
		(cur_box.max_col != '0);

	lbb_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (read_do),
		.present(present),
		.box    (cur_box),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

[design/lbb_box_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label bounding-box store
// Box memory with registered read, per-label seen bits and a one-entry
// write bypass so that back-to-back updates of one label see fresh data.
// ----------------------------------------------------------------------------
module lbb_box_store
	import lbb_pkg::*;
#(
	parameter int NUM_LABELS = 256,
	parameter int LW         = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [LW-1:0] rd_label,
	input  logic [LW-1:0] cur_label,
	input  store_ctl_t    ctl,
	input  logic [LW-1:0] wr_label,
	input  box_t          wr_box,
	output box_t          cur_box,
	output logic          cur_seen
);

	box_t                  mem [NUM_LABELS];
	box_t                  rd_q;
	logic [NUM_LABELS-1:0] seen_q;
	logic                  byp_valid_q;
	logic [LW-1:0]         byp_label_q;
	box_t                  byp_box_q;

	// Read and write share an edge; the read returns the old entry, which the
	// bypass below replaces when the write hit the same label.
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_label];
		if (ctl.wr_en) begin
			mem[wr_label] <= wr_box;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			if (ctl.clear_all) begin
				seen_q <= '0;
			end else if (ctl.wr_en) begin
				seen_q[wr_label] <= 1'b1;
			end
			byp_valid_q <= ctl.wr_en;
		end
	end

	always_ff @(posedge clk) begin
		byp_label_q <= wr_label;
		byp_box_q   <= wr_box;
	end

	assign cur_box  = (byp_valid_q && (byp_label_q == cur_label)) ? byp_box_q : rd_q;
	assign cur_seen = seen_q[cur_label];

endmodule

[design/lbb_result.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label bounding-box result stage
// Forms the center of a box and registers the read result and its strobe.
// ----------------------------------------------------------------------------
module lbb_result
	import lbb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  logic present,
	input  box_t box,
	output rsp_t rsp,
	output logic done
);

	rsp_t   rsp_d;
	rsp_t   rsp_q;
	logic   done_q;
	coord_t span_row;
	coord_t span_col;

	always_comb begin
		span_row = box.max_row - box.min_row;
		span_col = box.max_col - box.min_col;
		rsp_d    = '0;
		if (present) begin
			rsp_d.present    = 1'b1;
			rsp_d.min_row    = box.min_row;
			rsp_d.max_row    = box.max_row;
			rsp_d.min_col    = box.min_col;
			rsp_d.max_col    = box.max_col;
			rsp_d.center_row = box.min_row + (span_row >> 1);
			rsp_d.center_col = box.min_col + (span_col >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fire;
		end
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

[design/lbb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label bounding-box table checker
// Port-level checks of read timing and result consistency.
// ----------------------------------------------------------------------------
module lbb_checker
	import lbb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input rsp_t rsp,
	input logic done
);

	logic read_xfer;

	assign read_xfer = start && !busy && (req.operation == OP_READ);

	// Every read transfer produces a result with done high.
	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		read_xfer |-> ##2 done)
		else $error("read transfer without result");

	// No result appears without a matching earlier read transfer.
	a_result_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(read_xfer, 2))
		else $error("result without read transfer");

	// An absent label reports all fields as zero.
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.present) |-> (rsp.min_row == '0 && rsp.max_row == '0 &&
		rsp.min_col == '0 && rsp.max_col == '0 && rsp.center_row == '0 &&
		rsp.center_col == '0))
		else $error("absent label with nonzero fields");

	// A present box is ordered and its center lies inside it.
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.present) |-> (rsp.min_row <= rsp.center_row &&
		rsp.center_row <= rsp.max_row && rsp.min_col <= rsp.center_col &&
		rsp.center_col <= rsp.max_col && rsp.max_row != '0 && rsp.max_col != '0))
		else $error("present box out of order");

endmodule

bind label_bounding_box_table lbb_checker u_lbb_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.rsp   (rsp),
	.done  (done)
);

[sim/lbb_table_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label bounding-box table checker
// Scoreboard that tracks the per-label boxes from accepted commands and
// compares every read answer with the box it predicts.
// ----------------------------------------------------------------------------
package lbb_table_check_pkg;
	import lbb_pkg::*;

	localparam int TABLE_DEPTH = 1 << LABEL_W;
	localparam int REPORT_LINES = 40;

	class box_table_scoreboard;
		bit   label_seen [TABLE_DEPTH];
		box_t label_box [TABLE_DEPTH];
		rsp_t read_answers [$];
		int   error_count;

		function new();
			error_count = 0;
			foreach (label_seen[i]) begin
				label_seen[i] = 1'b0;
				label_box[i]  = '0;
			end
		endfunction

		function int pending();
			return read_answers.size();
		endfunction

		function void report(string msg);
			if (error_count < REPORT_LINES) begin
				$display("MISMATCH at %0t ns: %s", $time, msg);
			end
			error_count++;
		endfunction

		// Folds one accepted command into the table, queueing the answer of a read.
		function void note_command(req_t cmd);
			rsp_t answer;
			box_t b;
			logic [LABEL_W-1:0] lab;
			bit usable;

			lab    = cmd.pixel_label;
			usable = (lab != '0) && (lab != LABEL_IGNORED);
			case (cmd.operation)
				OP_CLEAR: begin
					foreach (label_seen[i]) label_seen[i] = 1'b0;
				end
				OP_PIXEL: begin
					// Every 10-bit coordinate lies inside the map, and every 8-bit
					// label inside the table, so only labels 0 and 255 drop out.
					if (usable) begin
						b = label_box[lab];
						if (!label_seen[lab]) begin
							b = '{cmd.pixel_row, cmd.pixel_row, cmd.pixel_col, cmd.pixel_col};
						end else begin
							if (cmd.pixel_row < b.min_row) b.min_row = cmd.pixel_row;
							if (cmd.pixel_row > b.max_row) b.max_row = cmd.pixel_row;
							if (cmd.pixel_col < b.min_col) b.min_col = cmd.pixel_col;
							if (cmd.pixel_col > b.max_col) b.max_col = cmd.pixel_col;
						end
						label_seen[lab] = 1'b1;
						label_box[lab]  = b;
					end
				end
				OP_READ: begin
					answer = '0;
					b = label_box[lab];
					if (usable && label_seen[lab] && b.max_row != '0 && b.max_col != '0) begin
						answer.present    = 1'b1;
						answer.min_row    = b.min_row;
						answer.max_row    = b.max_row;
						answer.min_col    = b.min_col;
						answer.max_col    = b.max_col;
						answer.center_row = b.min_row + ((b.max_row - b.min_row) >> 1);
						answer.center_col = b.min_col + ((b.max_col - b.min_col) >> 1);
					end
					read_answers.insert(read_answers.size(), answer);
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_field(string field, coord_t got, coord_t want);
			if (got !== want) begin
				report($sformatf("%s is %0d, expected %0d", field, got, want));
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;

			if (read_answers.size() == 0) begin
				report("read answer with no read outstanding");
				return;
			end
			want = read_answers.pop_front();
			compare_field("present", coord_t'(got.present), coord_t'(want.present));
			compare_field("min_row", got.min_row, want.min_row);
			compare_field("max_row", got.max_row, want.max_row);
			compare_field("min_col", got.min_col, want.min_col);
			compare_field("max_col", got.max_col, want.max_col);
			compare_field("center_row", got.center_row, want.center_row);
			compare_field("center_col", got.center_col, want.center_col);
		endfunction
	endclass

endpackage

[sim/label_bounding_box_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label bounding-box table testbench
// Drives clear, pixel and read commands through the start/busy handshake,
// first a directed set of corner cases and then random label maps under
// several sender idling patterns. Every read answer is checked field by
// field against a scoreboard that rebuilds the box table.
// ----------------------------------------------------------------------------
module label_bounding_box_table_test;
	import lbb_pkg::*;
	import lbb_table_check_pkg::*;

	// The fourth operation code has no meaning; the block must drop it.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RESET_CYCLES   = 5;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_ITEMS    = 145;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	rsp_t rsp;
	logic done;

	box_table_scoreboard box_tracker;

	// Labels that have had at least one pixel since reset. The box store is
	// undefined until written, so reads are only aimed at these labels (or at
	// the two ignored labels, which never touch the store).
	bit ever_written [TABLE_DEPTH];
	int idle_cycles = 0;

	always #2 clk = ~clk;

	label_bounding_box_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.rsp    (rsp),
		.done   (done)
	);

	// Monitor: a command transfer happens at an edge where start is high and
	// busy is low; a result transfer at any edge where done is high. Commands
	// are noted before results are checked so a same-edge pair stays ordered.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				box_tracker.note_command(req);
			end
			if (done) begin
				box_tracker.check_result(rsp);
			end
		end
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: a long run of cycles without any transfer means the block hung
	// or a read answer never came back.
	initial begin
		@(posedge clk);
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	function automatic req_t pack_command(logic [OP_W-1:0] op, logic [LABEL_W-1:0] lab,
			int unsigned row, int unsigned col);
		req_t cmd;

		cmd.operation   = op;
		cmd.pixel_label = lab;
		cmd.pixel_row   = coord_t'(row);
		cmd.pixel_col   = coord_t'(col);
		return cmd;
	endfunction

	// Coordinates lean on the map edges so boxes reach both extremes.
	function automatic coord_t random_coord();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return coord_t'($urandom_range(0, 1023));
		endcase
	endfunction

	// Most traffic goes to a dozen busy labels at both ends of the range so
	// boxes grow over many pixels; the rest is spread or hits ignored labels.
	function automatic logic [LABEL_W-1:0] random_label();
		case ($urandom_range(19))
			0: return '0;
			1: return LABEL_IGNORED;
			2, 3, 4: return LABEL_W'($urandom_range(1, 254));
			default: begin
				if ($urandom_range(1)) return LABEL_W'($urandom_range(1, 6));
				return LABEL_W'($urandom_range(249, 254));
			end
		endcase
	endfunction

	function automatic req_t random_command();
		req_t cmd;
		int unsigned pick;

		cmd.pixel_label = random_label();
		cmd.pixel_row   = random_coord();
		cmd.pixel_col   = random_coord();
		pick = $urandom_range(99);
		if (pick < 2) begin
			cmd.operation = OP_CLEAR;
		end else if (pick < 4) begin
			cmd.operation = OP_UNUSED;
		end else if (pick < 68) begin
			cmd.operation = OP_PIXEL;
		end else begin
			cmd.operation = OP_READ;
			if (cmd.pixel_label != '0 && cmd.pixel_label != LABEL_IGNORED
					&& !ever_written[cmd.pixel_label]) begin
				cmd.pixel_label = LABEL_IGNORED;
			end
		end
		return cmd;
	endfunction

	// Holds start high with the command until the transfer edge. Start is left
	// high afterwards so back-to-back commands need no second assignment.
	task automatic send_command(req_t cmd);
		start <= 1'b1;
		req   <= cmd;
		do @(posedge clk); while (busy);
		if (cmd.operation == OP_PIXEL && cmd.pixel_label != '0
				&& cmd.pixel_label != LABEL_IGNORED) begin
			ever_written[cmd.pixel_label] = 1'b1;
		end
	endtask

	// An idle slot with no command; the payload carries noise meanwhile.
	task automatic idle_cycle();
		logic [31:0] noise;

		noise = $urandom;
		start <= 1'b0;
		req   <= noise[$bits(req_t)-1:0];
		@(posedge clk);
	endtask

	// Geometric gap before the next command: each cycle is skipped with the
	// given chance in percent.
	task automatic sender_gap(int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) idle_cycle();
	endtask

	// Stop sending until every outstanding read has been answered.
	task automatic wait_for_answers();
		start <= 1'b0;
		@(posedge clk);
		while (box_tracker.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned phase_idle [4];

		phase_idle  = '{0, 88, 0, 32};
		box_tracker = new();
		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Ignored labels read as absent, and pixels on them change nothing.
		send_command(pack_command(OP_READ, 8'd0, 0, 0));
		send_command(pack_command(OP_READ, LABEL_IGNORED, 1023, 1023));
		send_command(pack_command(OP_PIXEL, 8'd0, 5, 5));
		send_command(pack_command(OP_PIXEL, LABEL_IGNORED, 6, 6));
		send_command(pack_command(OP_READ, 8'd0, 0, 0));
		send_command(pack_command(OP_READ, LABEL_IGNORED, 0, 0));
		// A seen label whose maxima are still zero reads as absent.
		send_command(pack_command(OP_PIXEL, 8'd1, 0, 0));
		send_command(pack_command(OP_READ, 8'd1, 0, 0));
		// Opposite map corners give the widest box.
		send_command(pack_command(OP_PIXEL, 8'd1, 1023, 1023));
		send_command(pack_command(OP_READ, 8'd1, 0, 0));
		// Zero max column only, then the box widens to become present.
		send_command(pack_command(OP_PIXEL, 8'd254, 1023, 0));
		send_command(pack_command(OP_READ, 8'd254, 0, 0));
		send_command(pack_command(OP_PIXEL, 8'd254, 512, 7));
		send_command(pack_command(OP_READ, 8'd254, 1023, 1023));
		// Consecutive pixels on the same label, including a repeat, then one shifting two bounds.
		send_command(pack_command(OP_PIXEL, 8'd2, 3, 9));
		send_command(pack_command(OP_PIXEL, 8'd2, 3, 9));
		send_command(pack_command(OP_PIXEL, 8'd2, 1, 12));
		send_command(pack_command(OP_READ, 8'd2, 0, 0));
		send_command(pack_command(OP_PIXEL, 8'd128, 682, 341));
		send_command(pack_command(OP_UNUSED, 8'd128, 1, 1));
		send_command(pack_command(OP_READ, 8'd128, 341, 682));
		// A clear forgets every label; the next pixel starts a fresh box.
		send_command(pack_command(OP_CLEAR, 8'd77, 100, 200));
		send_command(pack_command(OP_READ, 8'd1, 0, 0));
		send_command(pack_command(OP_PIXEL, 8'd1, 10, 20));
		send_command(pack_command(OP_READ, 8'd1, 0, 0));
		wait_for_answers();

		// Random label maps, one idling pattern per phase, draining the reads
		// between phases.
		foreach (phase_idle[p]) begin
			repeat (PHASE_ITEMS) begin
				sender_gap(phase_idle[p]);
				send_command(random_command());
			end
			wait_for_answers();
		end

		// Give a stray late answer time to show up.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (box_tracker.error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
design/lbb_pkg.sv
design/lbb_box_store.sv
design/lbb_result.sv
design/label_bounding_box_table.sv
design/lbb_checker.sv
sim/lbb_table_check_pkg.sv
sim/label_bounding_box_table_test.sv
